>>> rtl/text_console_char_writer_macros.svh
// Assertion macros for the text console character writer.
// Expects clock and reset in the scope of the module that uses them.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Same-cycle implication, idle during reset
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tccw_pkg.sv
// Package for the text console character writer: request and response
// structs, state codes, character codes and saturating add. No dependencies.
package tccw_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_LINES   = 25;
   localparam int DEF_TAB_STEP       = 8;

   localparam logic [15:0] BLANK_CELL  = 16'h0020;
   localparam logic [15:0] LOC_STRIDE  = 16'd80;
   localparam logic [7:0]  CH_NEWLINE  = 8'd10;
   localparam logic [7:0]  CH_TAB      = 8'd9;
   localparam logic [7:0]  POS_MAX     = 8'hFF;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic [7:0] color;
      logic [7:0] set_column;
      logic [7:0] set_row;
   } req_type;

   typedef struct packed {
      logic [15:0] cursor_location;
      logic [7:0]  cursor_column;
      logic [7:0]  cursor_row;
      logic        cell_written;
      logic [15:0] cell_index;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCROLL = 5'b00100,
      ST_BLANK  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? POS_MAX : s[7:0];
   endfunction

endpackage

>>> rtl/text_console_char_writer.sv
// Text console character writer: cursor control and screen store.
// Depends on tccw_pkg and text_console_char_writer_macros.svh.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one request at a time:
//    mode 0 prints char_code with color (newline and tab handled), mode 1
//    moves the cursor to set_column/set_row.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns one response per
//    request: cursor position, location and details of any cell write.
//  - A request without scroll goes from the response stage to the output
//    register once that is free; the next request waits until it has moved.
//  - A request that scrolls walks the cell memory (separate read and write
//    ports): one cell copy per cycle moves each row up by one, then the last
//    row is blanked, then the response stage.
//  - After reset a clearing pass fills all SCREEN_COLUMNS*SCREEN_LINES cells
//    (2000 by default) with blanks; req_ready stays low until it ends.
//  - Cursor resets to column 0, row 0. A response waiting on rsp_ready
//    does not block the next request; a second finished response holds in
//    the response stage until the output register frees up.
module text_console_char_writer
   import tccw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int SCREEN_LINES   = DEF_SCREEN_LINES,
   parameter int TAB_STEP       = DEF_TAB_STEP
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "text_console_char_writer_macros.svh"

   localparam int CELLS  = SCREEN_COLUMNS * SCREEN_LINES;
   localparam int AW     = $clog2(CELLS);
   localparam int COPY_N = (SCREEN_LINES - 1) * SCREEN_COLUMNS;

   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_END  = AW'(COPY_N);
   localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_COLUMNS);
   localparam logic [8:0]    COLS9     = 9'(SCREEN_COLUMNS);
   localparam logic [8:0]    LINES9    = 9'(SCREEN_LINES);
   localparam logic [7:0]    LAST_ROW  = 8'(SCREEN_LINES - 1);
   localparam logic [7:0]    TAB8      = 8'(TAB_STEP);
   localparam logic [15:0]   COLS16    = 16'(SCREEN_COLUMNS);

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [7:0]    col_ff, col_in;
   logic [7:0]    row_ff, row_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [15:0]   cells [CELLS];
   logic [15:0]   rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_wdata;

   logic [7:0]    nx_col;
   logic [7:0]    nx_row;
   rsp_type       nx_res;
   logic          load;

   // Cursor update for one request
   always_comb begin
      logic [7:0]  c;
      logic [7:0]  r;
      logic        scr;
      logic        wr;
      logic [15:0] idx;
      c   = col_ff;
      r   = row_ff;
      scr = 1'b0;
      wr  = 1'b0;
      idx = '0;
      if (req_data.mode) begin
         c = req_data.set_column;
         r = req_data.set_row;
      end else if (req_data.char_code == CH_NEWLINE) begin
         c = '0;
         r = sat_add(r, 8'd1);
      end else if (req_data.char_code == CH_TAB) begin
         c = sat_add(c, TAB8);
      end else begin
         wr = 1'b1;
         if ({1'b0, c} >= COLS9) begin
            c = '0;
            r = sat_add(r, 8'd1);
         end
      end
      if (!req_data.mode && ({1'b0, r} >= LINES9)) begin
         scr = 1'b1;
         r   = LAST_ROW;
         c   = '0;
      end
      if (wr) begin
         idx = 16'(r) * COLS16 + 16'(c);
         c   = sat_add(c, 8'd1);
      end
      nx_col = c;
      nx_row = r;
      nx_res.cursor_location = 16'(r) * LOC_STRIDE + 16'(c);
      nx_res.cursor_column   = c;
      nx_res.cursor_row      = r;
      nx_res.cell_written    = wr;
      nx_res.cell_index      = idx;
      nx_res.cell_value      = wr ? {req_data.color, req_data.char_code} : 16'd0;
      nx_res.scrolled        = scr;
   end

   assign load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = BLANK_CELL;
      mem_raddr    = cnt_ff + ROW_STEP;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load;
      rsp_data_in  = load ? res_ff : rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               col_in   = nx_col;
               row_in   = nx_row;
               res_in   = nx_res;
               cnt_in   = '0;
               state_in = nx_res.scrolled ? ST_SCROLL : ST_DONE;
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write back the cell read last cycle
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff == COPY_END) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            mem_we    = res_ff.cell_written;
            mem_waddr = res_ff.cell_index[AW-1:0];
            mem_wdata = res_ff.cell_value;
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TCCW_ASSERT_NOW(a_scroll_row, (state_ff == ST_DONE) && res_ff.scrolled, res_ff.cursor_row == LAST_ROW, "scrolled response not on last row")
   `TCCW_ASSERT_NOW(a_cell_on_screen, (state_ff == ST_DONE) && res_ff.cell_written, res_ff.cell_index < 16'(CELLS), "cell write off screen")
   `TCCW_ASSERT_NOW(a_copy_bound, state_ff == ST_SCROLL, cnt_ff <= COPY_END, "scroll copy past end")
   `TCCW_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE, "request accepted without leaving idle")

endmodule

>>> sim/tb.sv
// Testbench for text_console_char_writer: directed and random requests with
// random sender bursts and receiver stalls, checked against a cursor predictor.
// Depends on tccw_pkg and the text_console_char_writer RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tccw_pkg::*;

   localparam logic MODE_PUT    = 1'b0;
   localparam logic MODE_CURSOR = 1'b1;
   localparam int   COLUMNS     = DEF_SCREEN_COLUMNS;
   localparam int   LINES       = DEF_SCREEN_LINES;
   localparam int   TAB         = DEF_TAB_STEP;
   localparam int   RANDOM_REQUESTS = 1400;
   localparam int   DRAIN_CYCLES    = 50;
   localparam int   CYCLE_LIMIT     = 12_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0] cur_col = '0;
   logic [7:0] cur_row = '0;
   rsp_type    awaited_reports[$];
   int         fail_count = 0;
   int         burst_left = 0;
   int         cycle_count = 0;
   int         stall_style = 0;
   int         stall_phase_left = 0;

   text_console_char_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // receiver: phases of always ready, coin-flip ready and long stalls
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_style      <= $urandom_range(0, 2);
         stall_phase_left <= $urandom_range(20, 300);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic logic [7:0] clamp_add(input logic [7:0] a, input int b);
      int s;
      s = int'(a) + b;
      return (s > 255) ? 8'hFF : s[7:0];
   endfunction

   function automatic logic scroll_if_past_bottom();
      if (cur_row < LINES) return 1'b0;
      cur_row = 8'(LINES - 1);
      cur_col = '0;
      return 1'b1;
   endfunction

   function automatic rsp_type console_step(input req_type r);
      rsp_type o;
      int      idx;
      int      loc;
      o = '0;
      if (r.mode == MODE_CURSOR) begin
         cur_col = r.set_column;
         cur_row = r.set_row;
      end else if (r.char_code == CH_NEWLINE) begin
         cur_col    = '0;
         cur_row    = clamp_add(cur_row, 1);
         o.scrolled = scroll_if_past_bottom();
      end else if (r.char_code == CH_TAB) begin
         cur_col    = clamp_add(cur_col, TAB);
         o.scrolled = scroll_if_past_bottom();
      end else begin
         if (cur_col >= COLUMNS) begin
            cur_col = '0;
            cur_row = clamp_add(cur_row, 1);
         end
         o.scrolled     = scroll_if_past_bottom();
         idx            = int'(cur_row) * COLUMNS + int'(cur_col);
         o.cell_written = 1'b1;
         o.cell_index   = idx[15:0];
         o.cell_value   = {r.color, r.char_code};
         cur_col        = clamp_add(cur_col, 1);
      end
      loc               = int'(cur_row) * int'(LOC_STRIDE) + int'(cur_col);
      o.cursor_location = loc[15:0];
      o.cursor_column   = cur_col;
      o.cursor_row      = cur_row;
      return o;
   endfunction

   function automatic req_type put_char(input logic [7:0] ch, input logic [7:0] colour);
      req_type r;
      r.mode       = MODE_PUT;
      r.char_code  = ch;
      r.color      = colour;
      r.set_column = 8'($urandom_range(0, 255));
      r.set_row    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type move_to(input logic [7:0] col, input logic [7:0] row);
      req_type r;
      r.mode       = MODE_CURSOR;
      r.char_code  = 8'($urandom_range(0, 255));
      r.color      = 8'($urandom_range(0, 255));
      r.set_column = col;
      r.set_row    = row;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      burst_left--;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_reports.push_back(console_step(r));
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("cursor_location", want.cursor_location,
                        rsp_data.cursor_location);
            check_field("cursor_column", 16'(want.cursor_column),
                        16'(rsp_data.cursor_column));
            check_field("cursor_row", 16'(want.cursor_row),
                        16'(rsp_data.cursor_row));
            check_field("cell_written", 16'(want.cell_written),
                        16'(rsp_data.cell_written));
            check_field("cell_index", want.cell_index, rsp_data.cell_index);
            check_field("cell_value", want.cell_value, rsp_data.cell_value);
            check_field("scrolled", 16'(want.scrolled), 16'(rsp_data.scrolled));
         end
      end
   end

   task automatic test_printable_extremes();
      req_type r;
      r = put_char(8'h00, 8'h00);
      r.set_column = 8'hFF;
      r.set_row    = 8'hFF;
      send_request(r);
      r = put_char(8'hFF, 8'hFF);
      r.set_column = 8'h00;
      r.set_row    = 8'h00;
      send_request(r);
      send_request(put_char(8'd8, 8'hA5));
      send_request(put_char(8'd11, 8'h5A));
   endtask

   task automatic test_cursor_set();
      send_request(move_to(8'hFF, 8'hFF));
      send_request(move_to(8'h00, 8'h00));
      send_request(move_to(8'(COLUMNS - 1), 8'h00));
   endtask

   task automatic test_line_wrap();
      send_request(put_char("A", 8'h07));
      send_request(put_char("B", 8'h07));
      send_request(move_to(8'hFF, 8'd3));
      send_request(put_char("C", 8'h1F));
   endtask

   task automatic test_tab();
      send_request(move_to(8'd250, 8'd2));
      send_request(put_char(CH_TAB, 8'h00));
      send_request(put_char(CH_TAB, 8'hFF));
      send_request(put_char("D", 8'h70));
   endtask

   task automatic test_newline_scroll();
      send_request(move_to(8'd10, 8'(LINES - 1)));
      send_request(put_char(CH_NEWLINE, 8'h00));
      send_request(move_to(8'd7, 8'hFF));
      send_request(put_char(CH_NEWLINE, 8'h00));
      send_request(move_to(8'd5, 8'd200));
      send_request(put_char("E", 8'h4E));
      send_request(move_to(8'd0, 8'd30));
      send_request(put_char(CH_TAB, 8'h00));
   endtask

   // mostly text with line breaks and tabs, with some cursor jumps off-screen
   task automatic test_random_text();
      int pick;
      logic [7:0] col;
      logic [7:0] row;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_request(put_char(CH_NEWLINE, 8'($urandom_range(0, 255))));
         end else if (pick < 8) begin
            send_request(put_char(CH_TAB, 8'($urandom_range(0, 255))));
         end else if (pick < 12) begin
            col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, COLUMNS));
            row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, LINES - 1));
            send_request(move_to(col, row));
         end else begin
            send_request(put_char(8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255))));
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_printable_extremes();
      test_cursor_set();
      test_line_wrap();
      test_tab();
      test_newline_scroll();
      test_random_text();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
